// File: src/drsc_pkg.sv
package drsc_pkg;

  // screen geometry and strip sizing
  localparam int unsigned SCREEN_WIDTH  = 240;
  localparam int unsigned SCREEN_HEIGHT = 320;
  localparam int unsigned STRIP_ROWS    = 40;
  localparam int unsigned BUFFER_COUNT  = 2;
  localparam int unsigned MAX_CHUNKS    = 8;

  // field widths of the chunk descriptor
  localparam int unsigned COL_W   = 8;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned BUF_W   = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int unsigned CHUNK_W = $clog2(MAX_CHUNKS);

  // strip pixel budget, the dividend of the rows-per-chunk division
  localparam int unsigned STRIP_PIXELS = SCREEN_WIDTH * STRIP_ROWS;
  localparam int unsigned DVD_W        = $clog2(STRIP_PIXELS + 1);
  localparam int unsigned DIV_CNT_W    = $clog2(DVD_W + 1);

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 4 * COORD_W;
  localparam int unsigned OUT_BITS   = 2 * COL_W + 2 * ROW_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // input item kinds
  localparam logic KIND_PRESENT = 1'b0;
  localparam logic KIND_RECT    = 1'b1;

  // result status codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_UNAVAILABLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [COL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/drsc_div.sv
module drsc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drsc_pkg::div_req_t req_i,
  output drsc_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic [drsc_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [drsc_pkg::COL_W:0]            rem_q, rem_d;
  logic [drsc_pkg::DVD_W-1:0]          quo_q, quo_d;
  logic [drsc_pkg::COL_W-1:0]          dvs_q, dvs_d;
  logic [drsc_pkg::COL_W:0]            rem_shift;
  logic                                fits;

  // one restoring step per cycle: shift in a dividend bit, trial subtract
  always_comb begin
    rem_shift = {rem_q[drsc_pkg::COL_W-1:0], quo_q[drsc_pkg::DVD_W-1]};
    fits      = rem_shift >= {1'b0, dvs_q};
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = drsc_pkg::DIV_CNT_W'(drsc_pkg::DVD_W);
      rem_d  = '0;
      quo_d  = drsc_pkg::DVD_W'(drsc_pkg::STRIP_PIXELS);
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
        rem_d = fits ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
        quo_d = {quo_q[drsc_pkg::DVD_W-2:0], fits};
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = busy_q && (cnt_q == '0);
  assign rsp_o.quotient = quo_q;

endmodule

// File: src/dirty_rect_strip_chunker_core.sv
// dirty rectangle strip chunker
// plans partial display updates. the slave stream takes one item per
// transaction: tuser is the kind (present start or dirty rectangle), tdata the
// rectangle corners. the master stream gives chunk descriptors, tlast on the
// final descriptor of an item, tuser set on a display-unavailable status.
// the user must see that panel_ready is written through cfg_we_i / cfg_wdata_i
// only while idle; the block itself does not enforce it. a chunked rectangle
// is accepted, goes through the serial divider (one quotient bit per cycle for
// rows per chunk, plus a finish step), then gives its chunks in turn, at most
// 8 chunks, each as soon as the output register is free.
// the block works on one item at a time and holds s_axis_tready_o low until
// its last descriptor is in the output register. a stalled receiver holds the
// output register and the sequencer waits with it.
// reset clears panel_ready, the staging buffer index and the ignore flag and
// marks the first present as pending, so it will send the whole screen.
module dirty_rect_strip_chunker_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: panel_ready
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  // input items
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // rect_left, rect_top, rect_right, rect_bottom
  input  logic [drsc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // kind
  input  logic                              s_axis_tuser_i,
  // chunk descriptors
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // chunk_left, chunk_top, chunk_right, chunk_bottom, staging_buffer, zero pad
  output logic [drsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // status
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);

  localparam int unsigned CW  = drsc_pkg::COORD_W;
  localparam int unsigned SW  = drsc_pkg::COORD_W + 1;
  localparam int unsigned SUM_W = drsc_pkg::DVD_W + 1;
  localparam logic signed [SW-1:0] SCR_W_S = SW'(drsc_pkg::SCREEN_WIDTH);
  localparam logic signed [SW-1:0] SCR_H_S = SW'(drsc_pkg::SCREEN_HEIGHT);

  drsc_pkg::state_e state_q, state_d;

  logic panel_ready_q, first_pending_q, ignore_rects_q, unavail_q;
  logic [drsc_pkg::BUF_W-1:0]   buf_q;
  logic [drsc_pkg::CHUNK_W-1:0] n_q;

  logic [drsc_pkg::COL_W-1:0] l_q, r_q;
  logic [drsc_pkg::ROW_W-1:0] t_q, b_q, y_q;
  logic [drsc_pkg::DVD_W-1:0] rows_q;

  logic                               out_valid_q;
  logic [drsc_pkg::OUT_DATA_W-1:0]    out_data_q;
  logic                               out_status_q, out_last_q;

  drsc_pkg::div_req_t div_req;
  drsc_pkg::div_rsp_t div_rsp;

  // clipping of the incoming rectangle
  logic signed [SW-1:0] l_s, t_s, r_s, b_s, l_c, t_c, r_c, b_c;
  logic                 rect_empty;
  logic                 in_accept, out_free;
  logic                 start_full, start_rect;
  logic [drsc_pkg::COL_W-1:0] ld_l, ld_r;
  logic [drsc_pkg::ROW_W-1:0] ld_t, ld_b;

  // chunk step
  logic [SUM_W-1:0]           y_next;
  logic                       chunk_final;
  logic [drsc_pkg::ROW_W-1:0] chunk_end;
  logic [drsc_pkg::BUF_W-1:0] buf_next;
  logic                       emit_chunk, emit_unavail;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_comb begin
    l_s = SW'(signed'(s_axis_tdata_i[0*CW +: CW]));
    t_s = SW'(signed'(s_axis_tdata_i[1*CW +: CW]));
    r_s = SW'(signed'(s_axis_tdata_i[2*CW +: CW]));
    b_s = SW'(signed'(s_axis_tdata_i[3*CW +: CW]));
    l_c = (l_s < 0) ? '0 : l_s;
    t_c = (t_s < 0) ? '0 : t_s;
    r_c = (r_s > SCR_W_S) ? SCR_W_S : r_s;
    b_c = (b_s > SCR_H_S) ? SCR_H_S : b_s;
    rect_empty = (r_c <= l_c) || (b_c <= t_c);
  end

  // item decode at accept
  always_comb begin
    start_full = in_accept && (s_axis_tuser_i == drsc_pkg::KIND_PRESENT)
                 && panel_ready_q && first_pending_q;
    start_rect = in_accept && (s_axis_tuser_i == drsc_pkg::KIND_RECT)
                 && !ignore_rects_q && !rect_empty;
    if (start_full) begin
      ld_l = '0;
      ld_t = '0;
      ld_r = drsc_pkg::COL_W'(drsc_pkg::SCREEN_WIDTH);
      ld_b = drsc_pkg::ROW_W'(drsc_pkg::SCREEN_HEIGHT);
    end else begin
      ld_l = l_c[drsc_pkg::COL_W-1:0];
      ld_t = t_c[drsc_pkg::ROW_W-1:0];
      ld_r = r_c[drsc_pkg::COL_W-1:0];
      ld_b = b_c[drsc_pkg::ROW_W-1:0];
    end
    div_req.start   = start_full || start_rect;
    div_req.divisor = ld_r - ld_l;
  end

  drsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      drsc_pkg::ST_IDLE: begin
        if (div_req.start) begin
          state_d = drsc_pkg::ST_DIV;
        end else if (in_accept && (s_axis_tuser_i == drsc_pkg::KIND_PRESENT)
                     && !panel_ready_q) begin
          state_d = drsc_pkg::ST_EMIT;
        end
      end
      drsc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = drsc_pkg::ST_EMIT;
        end
      end
      drsc_pkg::ST_EMIT: begin
        if (out_free && (unavail_q || chunk_final)) begin
          state_d = drsc_pkg::ST_IDLE;
        end
      end
      default: state_d = drsc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and chunk arithmetic
  always_comb begin
    s_axis_tready_o = (state_q == drsc_pkg::ST_IDLE);
    emit_unavail    = (state_q == drsc_pkg::ST_EMIT) && out_free && unavail_q;
    emit_chunk      = (state_q == drsc_pkg::ST_EMIT) && out_free && !unavail_q;
    y_next      = SUM_W'(y_q) + SUM_W'(rows_q);
    chunk_final = (y_next >= SUM_W'(b_q))
                  || (n_q == drsc_pkg::CHUNK_W'(drsc_pkg::MAX_CHUNKS - 1));
    chunk_end   = (y_next >= SUM_W'(b_q)) ? b_q : y_next[drsc_pkg::ROW_W-1:0];
    if (buf_q == drsc_pkg::BUF_W'(drsc_pkg::BUFFER_COUNT - 1)) begin
      buf_next = '0;
    end else begin
      buf_next = buf_q + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= drsc_pkg::ST_IDLE;
      panel_ready_q   <= 1'b0;
      first_pending_q <= 1'b1;
      ignore_rects_q  <= 1'b0;
      unavail_q       <= 1'b0;
      buf_q           <= '0;
      n_q             <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        panel_ready_q <= cfg_wdata_i;
      end
      // present handling
      if (in_accept && (s_axis_tuser_i == drsc_pkg::KIND_PRESENT)) begin
        if (!panel_ready_q) begin
          ignore_rects_q <= 1'b1;
          unavail_q      <= 1'b1;
        end else if (first_pending_q) begin
          first_pending_q <= 1'b0;
          ignore_rects_q  <= 1'b1;
        end else begin
          ignore_rects_q <= 1'b0;
        end
      end
      if (div_req.start) begin
        n_q <= '0;
      end
      if (emit_unavail) begin
        unavail_q <= 1'b0;
      end
      if (emit_chunk) begin
        buf_q <= buf_next;
        n_q   <= n_q + 1'b1;
      end
      // output register
      if (emit_unavail || emit_chunk) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (div_req.start) begin
      l_q <= ld_l;
      r_q <= ld_r;
      t_q <= ld_t;
      b_q <= ld_b;
    end
    // rows per chunk, never below one
    if (div_rsp.done) begin
      rows_q <= (div_rsp.quotient == '0) ? drsc_pkg::DVD_W'(1) : div_rsp.quotient;
      y_q    <= t_q;
    end
    if (emit_chunk) begin
      y_q          <= chunk_end;
      out_data_q   <= drsc_pkg::OUT_DATA_W'({buf_next[0], chunk_end, r_q, y_q, l_q});
      out_status_q <= drsc_pkg::STATUS_OK;
      out_last_q   <= chunk_final;
    end else if (emit_unavail) begin
      out_data_q   <= '0;
      out_status_q <= drsc_pkg::STATUS_UNAVAILABLE;
      out_last_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: sim/tb_dirty_rect_strip_chunker_core.sv
`timescale 1ns / 100ps

module tb_dirty_rect_strip_chunker_core;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_PLAN,
    CHK_UNAVAIL,
    CHK_NONE
  } chk_e;

  // one chunk descriptor as the master stream carries it
  typedef struct packed {
    logic                       status;
    logic [drsc_pkg::COL_W-1:0] left;
    logic [drsc_pkg::ROW_W-1:0] top;
    logic [drsc_pkg::COL_W-1:0] right;
    logic [drsc_pkg::ROW_W-1:0] bottom;
    logic                       stage;
    logic                       last;
  } desc_t;

  // directed stimulus row, cfg_wr writes panel_ready before the item
  typedef struct packed {
    bit      cfg_wr;
    logic    cfg_val;
    logic    kind;
    shortint l;
    shortint t;
    shortint r;
    shortint b;
    chk_e    chk;
  } vec_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_we_i        = 1'b0;
  logic                            cfg_wdata_i     = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [drsc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                            s_axis_tuser_i  = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [drsc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tuser_o;
  logic                            m_axis_tlast_o;

  dirty_rect_strip_chunker_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // planner state mirrored in the bench
  logic  panel_up     = 1'b0;
  logic  full_pending = 1'b1;
  logic  skip_rects   = 1'b0;
  int    stage_idx    = 0;
  desc_t plan_q[$];

  desc_t want_q[$];
  int    errors     = 0;
  int    sent_items = 0;
  bit    burst_mode = 1'b0;
  int    stall_left = 0;

  // gap length for either side: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // clip a rectangle and cut it into row strips
  function automatic void plan_rect(input int l, input int t, input int r, input int b);
    int    w;
    int    rows;
    int    y;
    int    y_end;
    desc_t d;
    if (l < 0) l = 0;
    if (t < 0) t = 0;
    if (r > int'(drsc_pkg::SCREEN_WIDTH)) r = int'(drsc_pkg::SCREEN_WIDTH);
    if (b > int'(drsc_pkg::SCREEN_HEIGHT)) b = int'(drsc_pkg::SCREEN_HEIGHT);
    w = r - l;
    if (w <= 0 || b - t <= 0) return;
    rows = int'(drsc_pkg::STRIP_PIXELS) / w;
    if (rows < 1) rows = 1;
    for (y = t; y < b && plan_q.size() < int'(drsc_pkg::MAX_CHUNKS); y += rows) begin
      y_end     = (b - y < rows) ? b : y + rows;
      stage_idx = (stage_idx + 1) % int'(drsc_pkg::BUFFER_COUNT);
      d         = '0;
      d.status  = drsc_pkg::STATUS_OK;
      d.left    = l[drsc_pkg::COL_W-1:0];
      d.top     = y[drsc_pkg::ROW_W-1:0];
      d.right   = r[drsc_pkg::COL_W-1:0];
      d.bottom  = y_end[drsc_pkg::ROW_W-1:0];
      d.stage   = stage_idx[0];
      plan_q.push_back(d);
    end
  endfunction

  // descriptors caused by one input item, state updated on the way
  function automatic void plan_item(input logic kind, input shortint l, input shortint t,
                                    input shortint r, input shortint b);
    desc_t d;
    plan_q.delete();
    if (kind == drsc_pkg::KIND_PRESENT) begin
      if (!panel_up) begin
        skip_rects = 1'b1;
        d          = '0;
        d.status   = drsc_pkg::STATUS_UNAVAILABLE;
        plan_q.push_back(d);
      end else if (full_pending) begin
        full_pending = 1'b0;
        skip_rects   = 1'b1;
        plan_rect(0, 0, int'(drsc_pkg::SCREEN_WIDTH), int'(drsc_pkg::SCREEN_HEIGHT));
      end else begin
        skip_rects = 1'b0;
      end
    end else if (!skip_rects) begin
      plan_rect(l, t, r, b);
    end
    if (plan_q.size() > 0) plan_q[plan_q.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // push one transaction on the slave side and queue what it should cause
  task automatic send_item(input logic kind, input shortint l, input shortint t,
                           input shortint r, input shortint b, input chk_e chk);
    int    gap;
    desc_t d;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {b, r, t, l};
    do @(posedge clk_i); while (!s_axis_tready_o);
    plan_item(kind, l, t, r, b);
    case (chk)
      CHK_PLAN: begin
        foreach (plan_q[k]) want_q.push_back(plan_q[k]);
      end
      CHK_UNAVAIL: begin
        d        = '0;
        d.status = drsc_pkg::STATUS_UNAVAILABLE;
        d.last   = 1'b1;
        want_q.push_back(d);
      end
      default: ;
    endcase
    sent_items++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drain the block, then write panel_ready
  task automatic set_panel(input logic val);
    s_axis_tvalid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    panel_up = val;
  endtask

  task automatic make_rect(output shortint l, output shortint t,
                           output shortint r, output shortint b);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      // mostly on screen, any size
      l = shortint'(int'($urandom_range(0, 259)) - 10);
      t = shortint'(int'($urandom_range(0, 339)) - 10);
      r = shortint'(int'(l) + int'($urandom_range(1, 250)));
      b = shortint'(int'(t) + int'($urandom_range(1, 330)));
    end else if (sel < 68) begin
      // no width
      l = shortint'($urandom_range(0, 300));
      r = shortint'(int'(l) - int'($urandom_range(0, 20)));
      t = shortint'($urandom_range(0, 300));
      b = shortint'(int'(t) + int'($urandom_range(1, 50)));
    end else if (sel < 75) begin
      // no height
      l = shortint'($urandom_range(0, 200));
      r = shortint'(int'(l) + int'($urandom_range(1, 50)));
      t = shortint'($urandom_range(0, 340));
      b = shortint'(int'(t) - int'($urandom_range(0, 20)));
    end else begin
      l = shortint'($urandom());
      t = shortint'($urandom());
      r = shortint'($urandom());
      b = shortint'($urandom());
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin : rx_stall
    int gap;
    if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      gap = pick_gap();
      m_axis_tready_i <= (gap == 0);
      stall_left      <= (gap > 0) ? gap - 1 : 0;
    end
  end

  // compare each descriptor transaction with the oldest expectation
  always @(posedge clk_i) begin : rx_check
    desc_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (want_q.size() == 0) begin
        $error("unexpected descriptor: tdata %h tuser %b tlast %b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = want_q.pop_front();
        check_field("status", want.status, m_axis_tuser_o);
        check_field("chunk_left", want.left, m_axis_tdata_o[7:0]);
        check_field("chunk_top", want.top, m_axis_tdata_o[16:8]);
        check_field("chunk_right", want.right, m_axis_tdata_o[24:17]);
        check_field("chunk_bottom", want.bottom, m_axis_tdata_o[33:25]);
        check_field("staging_buffer", want.stage, m_axis_tdata_o[34]);
        check_field("last", want.last, m_axis_tlast_o);
      end
    end
  end

  // directed rows: panel down, first present, clipping extremes, empty cases
  vec_t dir_vec [24] = '{
    '{1'b0, 1'b0, drsc_pkg::KIND_PRESENT, 0, 0, 0, 0, CHK_UNAVAIL},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 0, 0, 10, 10, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_PRESENT, 0, 0, 0, 0, CHK_UNAVAIL},
    '{1'b1, 1'b1, drsc_pkg::KIND_PRESENT, 0, 0, 0, 0, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 0, 0, 240, 320, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_PRESENT, 0, 0, 0, 0, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, -32768, -32768, 32767, 32767, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 0, 0, 1, 1, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 239, 319, 240, 320, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 10, 10, 10, 50, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 10, 10, 50, 10, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 240, 0, 300, 100, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, -100, -100, 0, 0, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 0, 320, 240, 400, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 32767, 32767, -32768, -32768, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 0, 0, 240, 41, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 5, 100, 6, 320, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, -5, 0, 100, 320, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 1, 0, 240, 320, CHK_PLAN},
    '{1'b1, 1'b0, drsc_pkg::KIND_PRESENT, 0, 0, 0, 0, CHK_UNAVAIL},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 20, 20, 60, 60, CHK_NONE},
    '{1'b1, 1'b1, drsc_pkg::KIND_PRESENT, 0, 0, 0, 0, CHK_NONE},
    '{1'b0, 1'b0, drsc_pkg::KIND_RECT, 100, 50, 200, 60, CHK_PLAN},
    '{1'b0, 1'b0, drsc_pkg::KIND_PRESENT, 0, 0, 0, 0, CHK_NONE}
  };

  // stimulus
  initial begin
    shortint l;
    shortint t;
    shortint r;
    shortint b;
    int      n_rects;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_vec[i]) begin
      if (dir_vec[i].cfg_wr) set_panel(dir_vec[i].cfg_val);
      send_item(dir_vec[i].kind, dir_vec[i].l, dir_vec[i].t, dir_vec[i].r, dir_vec[i].b,
                dir_vec[i].chk);
    end

    // random frames: present then a few rectangles, with some stray items
    while (sent_items < 360) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      if (($urandom_range(0, 7) == 0) != !panel_up) set_panel(!panel_up);
      if ($urandom_range(0, 9) == 0) begin
        make_rect(l, t, r, b);
        send_item(drsc_pkg::KIND_RECT, l, t, r, b, CHK_PLAN);
      end
      if ($urandom_range(0, 19) != 0) begin
        send_item(drsc_pkg::KIND_PRESENT, shortint'($urandom()), shortint'($urandom()),
                  shortint'($urandom()), shortint'($urandom()), CHK_PLAN);
      end
      n_rects = $urandom_range(0, 6);
      repeat (n_rects) begin
        make_rect(l, t, r, b);
        send_item(drsc_pkg::KIND_RECT, l, t, r, b, CHK_PLAN);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: dirty_rect_strip_chunker_core.f
src/drsc_pkg.sv
src/drsc_div.sv
src/dirty_rect_strip_chunker_core.sv
sim/tb_dirty_rect_strip_chunker_core.sv
